// ===== rtl/uart_rb_pkg.sv =====
// shared types, register codes and helpers for the uart register block
package uart_rb_pkg;

    localparam int RX_FIFO_DEPTH = 16;
    localparam int RX_PTR_W      = (RX_FIFO_DEPTH > 1) ? $clog2(RX_FIFO_DEPTH) : 1;
    localparam int RX_FILL_W     = $clog2(RX_FIFO_DEPTH + 1);

    // item commands
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_RX_BYTE = 3'd2;
    localparam logic [2:0] CMD_BREAK   = 3'd3;
    localparam logic [2:0] CMD_TIMEOUT = 3'd4;

    // register word indexes
    localparam logic [3:0] REG_LINE  = 4'd0;
    localparam logic [3:0] REG_CTRL  = 4'd1;
    localparam logic [3:0] REG_FCTL  = 4'd2;
    localparam logic [3:0] REG_MCTL  = 4'd3;
    localparam logic [3:0] REG_STAT  = 4'd4;
    localparam logic [3:0] REG_ERR   = 4'd5;
    localparam logic [3:0] REG_FSTAT = 4'd6;
    localparam logic [3:0] REG_MSTAT = 4'd7;
    localparam logic [3:0] REG_TXH   = 4'd8;
    localparam logic [3:0] REG_RXH   = 4'd9;
    localparam logic [3:0] REG_BRD   = 4'd10;
    localparam logic [3:0] REG_FRAC  = 4'd11;
    localparam logic [3:0] REG_PEND  = 4'd12;
    localparam logic [3:0] REG_SRC   = 4'd13;
    localparam logic [3:0] REG_MASK  = 4'd14;

    // configuration indexes
    localparam logic CFG_CHANNEL = 1'b0;
    localparam logic CFG_TX_CONN = 1'b1;

    // interrupt source bits
    localparam logic [2:0] SRC_RXD = 3'b001;
    localparam logic [2:0] SRC_ERR = 3'b010;
    localparam logic [2:0] SRC_TXD = 3'b100;

    localparam logic [31:0] CTRL_RESET = 32'h0000_3000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  reg_index;
        logic [31:0] wdata;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_line;
        logic        dma_request;
        logic        tx_valid;
        logic [7:0]  tx_data;
    } out_item_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic       clear;
        logic [7:0] push_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic [RX_FILL_W-1:0] fill;
        logic [7:0]           head_data;
    } fifo_stat_t;

    // receive trigger level: (fctl[6:4] + 1) scaled by channel
    function automatic logic [8:0] trig_level(input logic [2:0] chan, input logic [2:0] lvl_code);
        logic [3:0] lvl;
        logic [8:0] res;
        lvl = {1'b0, lvl_code} + 4'd1;
        case (chan)
            3'd0:       res = {lvl, 5'b0};
            3'd1, 3'd4: res = {2'b0, lvl, 3'b0};
            3'd2, 3'd3: res = {4'b0, lvl, 1'b0};
            default:    res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/uart_rb_req_if.sv =====
// request channel: one item per word
interface uart_rb_req_if;
    import uart_rb_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/uart_rb_rsp_if.sv =====
// response channel: one result per word
interface uart_rb_rsp_if;
    import uart_rb_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

// ===== rtl/uart_rb_rx_fifo.sv =====
// receive fifo: byte store, ring pointers and occupancy count
module uart_rb_rx_fifo
    import uart_rb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_ctrl_t ctrl,
    output fifo_stat_t stat
);

    logic [7:0]           store [RX_FIFO_DEPTH];
    logic [RX_PTR_W-1:0]  head_reg, head_next;
    logic [RX_PTR_W-1:0]  tail_reg, tail_next;
    logic [RX_FILL_W-1:0] fill_reg, fill_next;

    localparam logic [RX_PTR_W-1:0] PTR_LAST = RX_PTR_W'(RX_FIFO_DEPTH - 1);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            store[tail_reg] <= ctrl.push_data;
        end
    end

    assign stat.fill      = fill_reg;
    assign stat.head_data = store[head_reg];

endmodule

// ===== rtl/uart_rb_core.sv =====
// register file, interrupt and dma logic; one item handled per fire
module uart_rb_core
    import uart_rb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  in_item_t   item,
    input  logic [2:0] channel,
    input  logic       tx_conn,
    input  fifo_stat_t fstat,
    output fifo_ctrl_t fctrl,
    output out_item_t  result
);

    logic [31:0] line_reg, line_next;
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] fctl_reg, fctl_next;
    logic [31:0] mctl_reg, mctl_next;
    logic [31:0] brd_reg, brd_next;
    logic [31:0] frac_reg, frac_next;
    logic [31:0] mask_reg, mask_next;
    logic [7:0]  rxh_reg, rxh_next;
    logic [2:0]  pend_reg, pend_next;
    logic [2:0]  src_reg, src_next;
    logic        ready_reg, ready_next;
    logic        tout_reg, tout_next;
    logic        brk_reg, brk_next;
    logic        dma_reg, dma_next;

    localparam logic [RX_FILL_W-1:0] FILL_FULL = RX_FILL_W'(RX_FIFO_DEPTH);

    always_comb
    begin
        logic [RX_FILL_W-1:0] fill_v;
        logic [31:0]          rd;
        logic                 txv;
        logic [7:0]           txd;
        logic                 irq_f;
        logic                 line_f;
        logic                 dma_f;
        logic                 hit;
        logic                 dma_val;
        fifo_ctrl_t           fc;

        line_next  = line_reg;
        ctrl_next  = ctrl_reg;
        fctl_next  = fctl_reg;
        mctl_next  = mctl_reg;
        brd_next   = brd_reg;
        frac_next  = frac_reg;
        mask_next  = mask_reg;
        rxh_next   = rxh_reg;
        pend_next  = pend_reg;
        src_next   = src_reg;
        ready_next = ready_reg;
        tout_next  = tout_reg;
        brk_next   = brk_reg;
        dma_next   = dma_reg;
        fill_v     = fstat.fill;
        rd         = '0;
        txv        = 1'b0;
        txd        = '0;
        irq_f      = 1'b0;
        line_f     = 1'b0;
        dma_f      = 1'b0;
        hit        = 1'b0;
        fc         = '0;

        case (item.cmd)
            CMD_WRITE:
            begin
                case (item.reg_index)
                    REG_LINE: line_next = item.wdata;
                    REG_BRD:  brd_next  = item.wdata;
                    REG_FRAC: frac_next = item.wdata;
                    REG_MCTL: mctl_next = item.wdata;
                    REG_FCTL:
                    begin
                        fctl_next = item.wdata;
                        if (item.wdata[1])
                        begin
                            fc.clear     = 1'b1;
                            fill_v       = '0;
                            ready_next   = 1'b0;
                            tout_next    = 1'b0;
                            pend_next    = pend_next & ~SRC_RXD;
                            src_next     = src_next & ~SRC_RXD;
                            line_f       = 1'b1;
                            fctl_next[1] = 1'b0;
                        end
                        if (item.wdata[2])
                        begin
                            fctl_next[2] = 1'b0;
                        end
                    end
                    REG_TXH:
                    begin
                        if (tx_conn)
                        begin
                            txv      = 1'b1;
                            txd      = item.wdata[7:0];
                            src_next = src_next | SRC_TXD;
                            irq_f    = 1'b1;
                        end
                    end
                    REG_PEND:
                    begin
                        pend_next = pend_next & ~item.wdata[2:0];
                        src_next  = src_next & ~item.wdata[2:0];
                        irq_f     = 1'b1;
                    end
                    REG_STAT:
                    begin
                        if (item.wdata[3])
                        begin
                            tout_next = 1'b0;
                        end
                        pend_next = pend_next & ~(SRC_TXD | SRC_RXD);
                        src_next  = src_next & ~(SRC_TXD | SRC_RXD);
                        line_f    = 1'b1;
                    end
                    REG_SRC: src_next = src_next & ~item.wdata[2:0];
                    REG_MASK:
                    begin
                        mask_next = item.wdata;
                        irq_f     = 1'b1;
                    end
                    REG_CTRL:
                    begin
                        ctrl_next = item.wdata;
                        if (item.wdata[3:2] == 2'b00)
                        begin
                            pend_next = pend_next & ~SRC_TXD;
                            src_next  = src_next & ~SRC_TXD;
                        end
                        if (item.wdata[1:0] == 2'b00)
                        begin
                            pend_next = pend_next & ~SRC_RXD;
                            src_next  = src_next & ~SRC_RXD;
                        end
                        line_f = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (item.reg_index)
                    REG_ERR:
                    begin
                        rd       = {28'b0, brk_reg, 3'b0};
                        brk_next = 1'b0;
                    end
                    REG_FSTAT: rd = (fstat.fill >= FILL_FULL) ? 32'h100 : 32'(fstat.fill);
                    REG_RXH:
                    begin
                        if (fctl_reg[0])
                        begin
                            if (fstat.fill != '0)
                            begin
                                rd         = 32'(fstat.head_data);
                                fc.pop     = 1'b1;
                                fill_v     = fstat.fill - 1'b1;
                                ready_next = (fill_v != '0);
                            end
                            else
                            begin
                                src_next = src_next | SRC_ERR;
                                irq_f    = 1'b1;
                            end
                        end
                        else
                        begin
                            ready_next = 1'b0;
                            rd         = 32'(rxh_reg);
                        end
                        dma_f = 1'b1;
                    end
                    REG_TXH:   rd = '0;
                    REG_MSTAT: rd = 32'd1;
                    REG_LINE:  rd = line_reg;
                    REG_CTRL:  rd = ctrl_reg;
                    REG_FCTL:  rd = fctl_reg;
                    REG_MCTL:  rd = mctl_reg;
                    REG_STAT:  rd = {28'b0, tout_reg, 2'b11, ready_reg};
                    REG_BRD:   rd = brd_reg;
                    REG_FRAC:  rd = frac_reg;
                    REG_PEND:  rd = 32'(pend_reg);
                    REG_SRC:   rd = 32'(src_reg);
                    REG_MASK:  rd = mask_reg;
                    default:   rd = '0;
                endcase
            end
            CMD_RX_BYTE:
            begin
                if (fctl_reg[0])
                begin
                    if (fstat.fill >= FILL_FULL)
                    begin
                        src_next = src_next | SRC_ERR;
                    end
                    else
                    begin
                        fc.push      = 1'b1;
                        fc.push_data = item.rx_byte;
                        fill_v       = fstat.fill + 1'b1;
                    end
                end
                else
                begin
                    rxh_next = item.rx_byte;
                end
                ready_next = 1'b1;
                src_next   = src_next | SRC_RXD;
                irq_f      = 1'b1;
            end
            CMD_BREAK:
            begin
                // null byte goes in only when there is room
                if (fstat.fill < FILL_FULL)
                begin
                    fc.push      = 1'b1;
                    fc.push_data = 8'h00;
                    fill_v       = fstat.fill + 1'b1;
                end
                brk_next = 1'b1;
                irq_f    = 1'b1;
            end
            CMD_TIMEOUT:
            begin
                if (ready_reg || ctrl_reg[11])
                begin
                    src_next  = src_next | SRC_RXD;
                    tout_next = 1'b1;
                    dma_f     = 1'b1;
                    irq_f     = 1'b1;
                end
            end
            default: ;
        endcase

        // common tail: irq evaluation, line refresh, dma flag
        dma_val = (ctrl_next[1:0] == 2'b10) && (fill_v == '0);
        if (irq_f)
        begin
            if (fctl_next[0])
            begin
                hit = 32'(fill_v) >= 32'(trig_level(channel, fctl_next[6:4]));
            end
            else
            begin
                hit = ready_next;
            end
            if (hit)
            begin
                dma_next = dma_val;
                src_next = src_next | SRC_RXD;
            end
            line_f = 1'b1;
        end
        if (line_f)
        begin
            pend_next = src_next & ~mask_next[2:0];
        end
        if (dma_f)
        begin
            dma_next = dma_val;
        end

        fctrl.push      = fc.push && fire;
        fctrl.pop       = fc.pop && fire;
        fctrl.clear     = fc.clear && fire;
        fctrl.push_data = fc.push_data;

        result.read_data   = rd;
        result.irq_line    = (pend_next != 3'b000);
        result.dma_request = dma_next;
        result.tx_valid    = txv;
        result.tx_data     = txd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg  <= '0;
            ctrl_reg  <= CTRL_RESET;
            fctl_reg  <= '0;
            mctl_reg  <= '0;
            brd_reg   <= '0;
            frac_reg  <= '0;
            mask_reg  <= '0;
            rxh_reg   <= '0;
            pend_reg  <= '0;
            src_reg   <= '0;
            ready_reg <= 1'b0;
            tout_reg  <= 1'b0;
            brk_reg   <= 1'b0;
            dma_reg   <= 1'b0;
        end
        else if (fire)
        begin
            line_reg  <= line_next;
            ctrl_reg  <= ctrl_next;
            fctl_reg  <= fctl_next;
            mctl_reg  <= mctl_next;
            brd_reg   <= brd_next;
            frac_reg  <= frac_next;
            mask_reg  <= mask_next;
            rxh_reg   <= rxh_next;
            pend_reg  <= pend_next;
            src_reg   <= src_next;
            ready_reg <= ready_next;
            tout_reg  <= tout_next;
            brk_reg   <= brk_next;
            dma_reg   <= dma_next;
        end
    end

endmodule

// ===== rtl/uart_register_block_rx_fifo_irq_unit.sv =====
// UART register block with receive fifo, interrupt and receive dma request.
// Each request word (register write, register read, received byte, break or
// receive timeout) yields exactly one response word. Throughput is one word
// per clock while responses are taken; a word is captured in the input
// register, handled by the core and loaded into the output register when that
// register is empty or its response is being taken, and the response is
// presented from the output register. While a response waits, one further
// request can still be captured; after that the input stalls, through ready,
// until the response is taken. Configuration (channel, tx_connected) takes
// effect at once and is meant to be written while no word is in flight.
module uart_register_block_rx_fifo_irq_unit
    import uart_rb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    uart_rb_req_if.sink       req,
    uart_rb_rsp_if.source     rsp,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [2:0]        cfg_wdata
);

    logic       in_valid_reg;
    in_item_t   in_word_reg;
    logic       out_valid_reg;
    out_item_t  out_word_reg;
    logic [2:0] channel_reg;
    logic       tx_conn_reg;
    logic       advance;
    fifo_ctrl_t fctrl;
    fifo_stat_t fstat;
    out_item_t  result;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            channel_reg   <= '0;
            tx_conn_reg   <= 1'b1;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CHANNEL: channel_reg <= cfg_wdata;
                    CFG_TX_CONN: tx_conn_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_word_reg <= req.word;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

    uart_rb_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .item    (in_word_reg),
        .channel (channel_reg),
        .tx_conn (tx_conn_reg),
        .fstat   (fstat),
        .fctrl   (fctrl),
        .result  (result)
    );

    uart_rb_rx_fifo u_rx_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fctrl),
        .stat  (fstat)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the uart register block with rx fifo and irq logic
module tb;
    import uart_rb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_WORDS = 105;

    // status, control, error and fifo bits used by the register shadow
    localparam logic [31:0] RXD_BIT    = 32'(SRC_RXD);
    localparam logic [31:0] ERR_BIT    = 32'(SRC_ERR);
    localparam logic [31:0] TXD_BIT    = 32'(SRC_TXD);
    localparam logic [31:0] STAT_RDY   = 32'h0000_0001;
    localparam logic [31:0] STAT_TOUT  = 32'h0000_0008;
    localparam logic [31:0] STAT_TXE   = 32'h0000_0006;
    localparam logic [31:0] CTRL_TOEN  = 32'h0000_0800;
    localparam logic [31:0] ERR_BREAK  = 32'h0000_0008;
    localparam logic [31:0] FSTAT_FULL = 32'h0000_0100;
    localparam logic [31:0] FCTL_RXRST = 32'h0000_0002;
    localparam logic [31:0] FCTL_TXRST = 32'h0000_0004;
    localparam logic [31:0] LINE_ONES  = 32'hffff_ffff;

    localparam logic [2:0] CHAN_PLAN [PHASES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};
    localparam logic       TXON_PLAN [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [2:0] cfg_wdata;

    uart_rb_req_if req_ch ();
    uart_rb_rsp_if rsp_ch ();

    uart_register_block_rx_fifo_irq_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // register shadow
    logic [31:0]          shadow_regs [0:14];
    logic [7:0]           rx_bytes [RX_FIFO_DEPTH];
    int unsigned          rx_rd_ptr;
    int unsigned          rx_wr_ptr;
    int unsigned          rx_count;
    logic                 rx_dma_flag;
    logic [2:0]           cfg_chan;
    logic                 cfg_tx_on;

    in_item_t             queued_requests [$];
    out_item_t            awaited_replies [$];

    bit                   req_taken = 1'b0;
    bit                   calm = 1'b0;
    int unsigned          cycle_count = 0;
    int unsigned          words_queued = 0;
    int unsigned          replies_checked = 0;
    int unsigned          mismatches = 0;
    int unsigned          overflow_drops = 0;
    int unsigned          full_reads = 0;
    int unsigned          tx_words = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned rx_threshold();
        int unsigned lvl;
        lvl = int'(shadow_regs[REG_FCTL][6:4]) + 1;
        case (cfg_chan)
            3'd0:       return lvl * 32;
            3'd1, 3'd4: return lvl * 8;
            3'd2, 3'd3: return lvl * 2;
            default:    return 0;
        endcase
    endfunction

    function automatic void refresh_dma();
        rx_dma_flag = (shadow_regs[REG_CTRL][1:0] == 2'b10) && (rx_count == 0);
    endfunction

    function automatic void refresh_pend();
        shadow_regs[REG_PEND] = shadow_regs[REG_SRC] & ~shadow_regs[REG_MASK];
    endfunction

    // rx source is raised on trigger level in fifo mode, on ready otherwise
    function automatic void raise_rx_irq();
        if (shadow_regs[REG_FCTL][0])
        begin
            if (rx_count >= rx_threshold())
            begin
                refresh_dma();
                shadow_regs[REG_SRC] |= RXD_BIT;
            end
        end
        else if (shadow_regs[REG_STAT] & STAT_RDY)
        begin
            refresh_dma();
            shadow_regs[REG_SRC] |= RXD_BIT;
        end
        refresh_pend();
    endfunction

    function automatic void rx_push(logic [7:0] b);
        rx_bytes[rx_wr_ptr] = b;
        rx_wr_ptr = (rx_wr_ptr + 1 >= RX_FIFO_DEPTH) ? 0 : rx_wr_ptr + 1;
        rx_count++;
    endfunction

    function automatic out_item_t uart_reg_step(in_item_t w);
        out_item_t   r;
        logic [31:0] v;
        r = '0;
        v = w.wdata;
        case (w.cmd)
            CMD_WRITE:
            begin
                case (w.reg_index)
                    REG_LINE, REG_BRD, REG_FRAC, REG_MCTL:
                        shadow_regs[w.reg_index] = v;
                    REG_FCTL:
                    begin
                        shadow_regs[REG_FCTL] = v;
                        if (v & FCTL_RXRST)
                        begin
                            rx_rd_ptr = 0;
                            rx_wr_ptr = 0;
                            rx_count = 0;
                            shadow_regs[REG_STAT] &= ~(STAT_RDY | STAT_TOUT);
                            shadow_regs[REG_PEND] &= ~RXD_BIT;
                            shadow_regs[REG_SRC] &= ~RXD_BIT;
                            refresh_pend();
                            shadow_regs[REG_FCTL] &= ~FCTL_RXRST;
                        end
                        if (v & FCTL_TXRST)
                            shadow_regs[REG_FCTL] &= ~FCTL_TXRST;
                    end
                    REG_TXH:
                    begin
                        if (cfg_tx_on)
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_data = v[7:0];
                            tx_words++;
                            shadow_regs[REG_STAT] |= STAT_TXE;
                            shadow_regs[REG_SRC] |= TXD_BIT;
                            raise_rx_irq();
                        end
                    end
                    REG_PEND:
                    begin
                        shadow_regs[REG_PEND] &= ~v;
                        shadow_regs[REG_SRC] &= ~v;
                        raise_rx_irq();
                    end
                    REG_STAT:
                    begin
                        if (v & STAT_TOUT)
                            shadow_regs[REG_STAT] &= ~STAT_TOUT;
                        shadow_regs[REG_PEND] &= ~(TXD_BIT | RXD_BIT);
                        shadow_regs[REG_SRC] &= ~(TXD_BIT | RXD_BIT);
                        refresh_pend();
                    end
                    REG_SRC:
                        shadow_regs[REG_SRC] &= ~v;
                    REG_MASK:
                    begin
                        shadow_regs[REG_MASK] = v;
                        raise_rx_irq();
                    end
                    REG_CTRL:
                    begin
                        shadow_regs[REG_CTRL] = v;
                        if (v[3:2] == 2'b00)
                        begin
                            shadow_regs[REG_PEND] &= ~TXD_BIT;
                            shadow_regs[REG_SRC] &= ~TXD_BIT;
                        end
                        if (v[1:0] == 2'b00)
                        begin
                            shadow_regs[REG_PEND] &= ~RXD_BIT;
                            shadow_regs[REG_SRC] &= ~RXD_BIT;
                        end
                        refresh_pend();
                    end
                    default: ;
                endcase
            end
            CMD_READ:
            begin
                case (w.reg_index)
                    REG_ERR:
                    begin
                        r.read_data = shadow_regs[REG_ERR];
                        shadow_regs[REG_ERR] = '0;
                    end
                    REG_FSTAT:
                    begin
                        r.read_data = 32'(rx_count & 8'hff);
                        if (rx_count >= RX_FIFO_DEPTH)
                        begin
                            r.read_data = FSTAT_FULL;
                            full_reads++;
                        end
                        shadow_regs[REG_FSTAT] = r.read_data;
                    end
                    REG_RXH:
                    begin
                        if (shadow_regs[REG_FCTL][0])
                        begin
                            if (rx_count != 0)
                            begin
                                r.read_data = 32'(rx_bytes[rx_rd_ptr]);
                                rx_rd_ptr = (rx_rd_ptr + 1 >= RX_FIFO_DEPTH) ? 0 : rx_rd_ptr + 1;
                                rx_count--;
                                if (rx_count == 0)
                                    shadow_regs[REG_STAT] &= ~STAT_RDY;
                                else
                                    shadow_regs[REG_STAT] |= STAT_RDY;
                            end
                            else
                            begin
                                // empty pop flags an error
                                shadow_regs[REG_SRC] |= ERR_BIT;
                                raise_rx_irq();
                            end
                        end
                        else
                        begin
                            shadow_regs[REG_STAT] &= ~STAT_RDY;
                            r.read_data = shadow_regs[REG_RXH];
                        end
                        refresh_dma();
                    end
                    REG_TXH:
                        r.read_data = '0;
                    REG_MSTAT:
                        r.read_data = shadow_regs[REG_MSTAT] | 32'h1;
                    default:
                        r.read_data = (w.reg_index < 4'd15) ? shadow_regs[w.reg_index] : '0;
                endcase
            end
            CMD_RX_BYTE:
            begin
                if (shadow_regs[REG_FCTL][0])
                begin
                    if (rx_count >= RX_FIFO_DEPTH)
                    begin
                        shadow_regs[REG_SRC] |= ERR_BIT;
                        overflow_drops++;
                    end
                    else
                        rx_push(w.rx_byte);
                end
                else
                    shadow_regs[REG_RXH] = 32'(w.rx_byte);
                shadow_regs[REG_STAT] |= STAT_RDY;
                shadow_regs[REG_SRC] |= RXD_BIT;
                raise_rx_irq();
            end
            CMD_BREAK:
            begin
                // null byte goes in even outside fifo mode, dropped when full
                if (rx_count < RX_FIFO_DEPTH)
                    rx_push(8'h00);
                shadow_regs[REG_ERR] |= ERR_BREAK;
                raise_rx_irq();
            end
            CMD_TIMEOUT:
            begin
                if ((shadow_regs[REG_STAT] & STAT_RDY) || (shadow_regs[REG_CTRL] & CTRL_TOEN))
                begin
                    shadow_regs[REG_SRC] |= RXD_BIT;
                    shadow_regs[REG_STAT] |= STAT_TOUT;
                    refresh_dma();
                    raise_rx_irq();
                end
            end
            default: ;
        endcase
        r.irq_line = (shadow_regs[REG_PEND] != '0);
        r.dma_request = rx_dma_flag;
        return r;
    endfunction

    task automatic log_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40)
            $display("mismatch at reply %0d (cycle %0d): %s = %0h, expected %0h",
                     replies_checked, cycle_count, field, got, want);
        mismatches++;
    endtask

    task automatic enqueue_word(logic [2:0] c, logic [3:0] idx, logic [31:0] d, logic [7:0] ch);
        in_item_t w;
        w.cmd = c;
        w.reg_index = idx;
        w.wdata = d;
        w.rx_byte = ch;
        queued_requests.push_back(w);
        words_queued++;
    endtask

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (queued_requests.size() != 0 || req_ch.valid || awaited_replies.size() != 0);
    endtask

    task automatic set_uart_config(logic [2:0] chan, logic tx_on);
        wait_quiet();
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CHANNEL;
        cfg_wdata <= chan;
        @(negedge clk);
        cfg_index <= CFG_TX_CONN;
        cfg_wdata <= {2'b00, tx_on};
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_chan = chan;
        cfg_tx_on = tx_on;
        @(posedge clk);
    endtask

    // mostly receive bursts and drains, with register traffic and noise mixed in
    task automatic fill_random_phase(int unsigned count);
        int unsigned stop_at;
        int unsigned n;
        logic [31:0] v;
        logic [3:0]  idx;
        stop_at = words_queued + count;
        while (words_queued < stop_at)
        begin
            case ($urandom_range(11))
                0, 1, 2:
                begin
                    n = $urandom_range(1, 20);
                    repeat (n)
                        enqueue_word(($urandom_range(9) == 0) ? CMD_BREAK : CMD_RX_BYTE,
                                     4'($urandom_range(15)), $urandom,
                                     8'($urandom_range(255)));
                    if ($urandom_range(1))
                        enqueue_word(CMD_READ, REG_FSTAT, $urandom, 8'($urandom_range(255)));
                    repeat ($urandom_range(0, n + 2))
                        enqueue_word(CMD_READ, ($urandom_range(7) == 0) ? REG_ERR : REG_RXH,
                                     $urandom, 8'($urandom_range(255)));
                end
                3:
                begin
                    v = $urandom;
                    v[0] = ($urandom_range(4) != 0);
                    v[1] = ($urandom_range(7) == 0);
                    enqueue_word(CMD_WRITE, REG_FCTL, v, 8'($urandom_range(255)));
                end
                4:
                    enqueue_word(CMD_WRITE, REG_CTRL, $urandom, 8'($urandom_range(255)));
                5:
                begin
                    case ($urandom_range(3))
                        0:       idx = REG_PEND;
                        1:       idx = REG_SRC;
                        2:       idx = REG_STAT;
                        default: idx = REG_MASK;
                    endcase
                    v = $urandom_range(1) ? 32'($urandom_range(15)) : $urandom;
                    enqueue_word(CMD_WRITE, idx, v, 8'($urandom_range(255)));
                end
                6:
                    enqueue_word($urandom_range(1) ? CMD_TIMEOUT : CMD_BREAK,
                                 4'($urandom_range(15)), $urandom, 8'($urandom_range(255)));
                7, 8:
                    enqueue_word(CMD_READ, 4'($urandom_range(15)), $urandom,
                                 8'($urandom_range(255)));
                9:
                    enqueue_word(CMD_WRITE, 4'($urandom_range(15)), $urandom,
                                 8'($urandom_range(255)));
                10:
                    enqueue_word(3'($urandom_range(7, 5)), 4'($urandom_range(15)), $urandom,
                                 8'($urandom_range(255)));
                default:
                    enqueue_word(CMD_WRITE, REG_TXH, $urandom, 8'($urandom_range(255)));
            endcase
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= 32))
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.word <= queued_requests.pop_front();
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // monitor: predict on each accepted request, check each accepted reply
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            cycle_count++;
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
                awaited_replies.push_back(uart_reg_step(req_ch.word));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_replies.size() == 0)
                    log_mismatch("unexpected word", rsp_ch.word.read_data, '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (rsp_ch.word.read_data !== want.read_data)
                        log_mismatch("read_data", rsp_ch.word.read_data, want.read_data);
                    if (rsp_ch.word.irq_line !== want.irq_line)
                        log_mismatch("irq_line", 32'(rsp_ch.word.irq_line), 32'(want.irq_line));
                    if (rsp_ch.word.dma_request !== want.dma_request)
                        log_mismatch("dma_request", 32'(rsp_ch.word.dma_request),
                                     32'(want.dma_request));
                    if (rsp_ch.word.tx_valid !== want.tx_valid)
                        log_mismatch("tx_valid", 32'(rsp_ch.word.tx_valid), 32'(want.tx_valid));
                    if (rsp_ch.word.tx_data !== want.tx_data)
                        log_mismatch("tx_data", 32'(rsp_ch.word.tx_data), 32'(want.tx_data));
                end
                replies_checked++;
            end
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d replies outstanding",
                         cycle_count, awaited_replies.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CHANNEL;
        cfg_wdata = 3'd0;
        req_ch.valid = 1'b0;
        req_ch.word = '0;
        rsp_ch.ready = 1'b0;

        for (int i = 0; i < 15; i++)
            shadow_regs[i] = '0;
        shadow_regs[REG_CTRL] = CTRL_RESET;
        shadow_regs[REG_STAT] = STAT_TXE;
        rx_rd_ptr = 0;
        rx_wr_ptr = 0;
        rx_count = 0;
        rx_dma_flag = 1'b0;
        cfg_chan = 3'd0;
        cfg_tx_on = 1'b1;

        // directed words at reset settings
        enqueue_word(CMD_READ, REG_CTRL, '0, 8'h00);
        enqueue_word(CMD_READ, REG_STAT, '0, 8'h00);
        enqueue_word(CMD_READ, REG_MSTAT, '0, 8'h00);
        enqueue_word(CMD_READ, 4'd15, LINE_ONES, 8'hff);
        enqueue_word(CMD_WRITE, 4'd15, LINE_ONES, 8'hff);
        enqueue_word(CMD_WRITE, REG_LINE, LINE_ONES, 8'h00);
        enqueue_word(CMD_READ, REG_LINE, '0, 8'h00);
        enqueue_word(CMD_WRITE, REG_ERR, LINE_ONES, 8'h00);
        enqueue_word(3'd7, 4'd15, LINE_ONES, 8'hff);
        enqueue_word(CMD_TIMEOUT, REG_LINE, '0, 8'h00);
        enqueue_word(CMD_WRITE, REG_TXH, LINE_ONES, 8'h00);
        enqueue_word(CMD_READ, REG_TXH, '0, 8'h00);
        enqueue_word(CMD_RX_BYTE, REG_LINE, '0, 8'hff);
        enqueue_word(CMD_READ, REG_STAT, '0, 8'h00);
        enqueue_word(CMD_READ, REG_RXH, '0, 8'h00);
        enqueue_word(CMD_WRITE, REG_FCTL, 32'h0000_0001, 8'h00);
        enqueue_word(CMD_READ, REG_RXH, '0, 8'h00);
        enqueue_word(CMD_BREAK, REG_LINE, '0, 8'h00);
        enqueue_word(CMD_READ, REG_FSTAT, '0, 8'h00);
        enqueue_word(CMD_READ, REG_RXH, '0, 8'h00);
        enqueue_word(CMD_READ, REG_ERR, '0, 8'h00);
        enqueue_word(CMD_WRITE, REG_MASK, LINE_ONES, 8'h00);
        enqueue_word(CMD_WRITE, REG_PEND, LINE_ONES, 8'h00);
        enqueue_word(CMD_WRITE, REG_STAT, STAT_TOUT, 8'h00);
        enqueue_word(CMD_WRITE, REG_SRC, LINE_ONES, 8'h00);
        enqueue_word(CMD_WRITE, REG_MASK, '0, 8'h00);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int unsigned ph = 0; ph < PHASES; ph++)
        begin
            set_uart_config(CHAN_PLAN[ph], TXON_PLAN[ph]);
            calm = (ph == 3);
            fill_random_phase(PHASE_WORDS);
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        $display("covered %0d request words over %0d channel settings, %0d replies compared",
                 words_queued, PHASES, replies_checked);
        $display("rx overflow drops %0d, full fifo status reads %0d, tx words %0d",
                 overflow_drops, full_reads, tx_words);
        if (mismatches == 0 && awaited_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/uart_rb_pkg.sv
rtl/uart_rb_req_if.sv
rtl/uart_rb_rsp_if.sv
rtl/uart_rb_rx_fifo.sv
rtl/uart_rb_core.sv
rtl/uart_register_block_rx_fifo_irq_unit.sv
tb/sv/tb.sv
